// ----- rtl/core/brp_pkg.sv -----
package brp_pkg;

  localparam int unsigned DIM_W       = 11;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned AXIS_DW     = 8;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PW    = 2;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } op_e;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic             sel;
    logic             enable;
    logic             write;
    reg_idx_e         idx;
    logic [DIM_W-1:0] wdata;
  } apb_req_t;

  typedef struct packed {
    op_e  op;
    logic pixel;
    logic row_end;
    logic frame_end;
    logic x_start;
    logic y_start;
  } cmd_flags_t;

  typedef struct packed {
    logic loaded;
    logic load_origin;
  } front_stat_t;

endpackage

// ----- rtl/core/border_run_pixel_clear.sv -----
// channel      dir  handshake                  payload
// apb config   in   psel/penable/pwrite/pready 0x0 frame_width, 0x4 frame_height
// s_axis       in   s_axis_tvalid/tready       tdata[0] pixel_in, tuser[0] opcode
// m_axis       out  m_axis_tvalid/tready       tdata[0] pixel_out, tuser[0] row_end,
//                                              tlast frame_end
//
// one item per cycle sustained on load and on emit while the output is not stalled;
// a load gives no transfer out
// an emit result passes from its input transfer into the four-entry command queue,
// then through the memory read stage and the output register
// one read and one write port per store; frame store, row and column span tables
// reset needs no clearing pass: span tables are rebuilt while each frame loads
// a stalled output holds only the back end, the front keeps taking items until
// the queue is full
module border_run_pixel_clear #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [brp_pkg::APB_AW-1:0]    paddr,
  input  logic [brp_pkg::APB_DW-1:0]    pwdata,
  output logic [brp_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [brp_pkg::AXIS_DW-1:0]   s_axis_tdata,  // [0] pixel_in
  input  logic [0:0]                    s_axis_tuser,  // [0] opcode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [brp_pkg::AXIS_DW-1:0]   m_axis_tdata,  // [0] pixel_out
  output logic [0:0]                    m_axis_tuser,  // [0] row_end
  output logic                          m_axis_tlast
);

  localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned FlagsW = $bits(brp_pkg::cmd_flags_t);
  localparam int unsigned QW = FlagsW + XW + YW;

  brp_pkg::apb_req_t    apb_req;
  brp_pkg::front_stat_t front_stat;
  brp_pkg::cmd_flags_t  f_flags, b_flags;
  logic [XW-1:0]        f_x, b_x;
  logic [YW-1:0]        f_y, b_y;
  logic                 f_valid, f_ready, b_valid, b_ready;
  logic [QW-1:0]        q_out;
  logic                 pixel_out;

  assign apb_req.sel    = psel;
  assign apb_req.enable = penable;
  assign apb_req.write  = pwrite;
  assign apb_req.idx    = brp_pkg::reg_idx_e'(paddr[2]);
  assign apb_req.wdata  = pwdata[brp_pkg::DIM_W-1:0];
  assign pready         = 1'b1;

  brp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .XW         (XW),
    .YW         (YW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .apb_i       (apb_req),
    .prdata_o    (prdata),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (brp_pkg::op_e'(s_axis_tuser[0])),
    .in_pixel_i  (s_axis_tdata[0]),
    .in_ready_o  (s_axis_tready),
    .cmd_valid_o (f_valid),
    .cmd_flags_o (f_flags),
    .cmd_x_o     (f_x),
    .cmd_y_o     (f_y),
    .cmd_ready_i (f_ready),
    .stat_o      (front_stat)
  );

  brp_fifo #(
    .DW (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_flags, f_x, f_y}),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (q_out)
  );

  assign b_flags = brp_pkg::cmd_flags_t'(q_out[QW-1 -: FlagsW]);
  assign b_x     = q_out[YW +: XW];
  assign b_y     = q_out[YW-1:0];

  brp_back #(
    .XW (XW),
    .YW (YW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (b_valid),
    .cmd_ready_o     (b_ready),
    .cmd_flags_i     (b_flags),
    .cmd_x_i         (b_x),
    .cmd_y_i         (b_y),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_pixel_o     (pixel_out),
    .out_row_end_o   (m_axis_tuser[0]),
    .out_frame_end_o (m_axis_tlast)
  );

  assign m_axis_tdata = brp_pkg::AXIS_DW'(pixel_out);

  a_frame_end_is_row_end: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0]
  ) else $error("frame end without row end");

  a_cfg_drops_frame: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite |=> !front_stat.loaded && front_stat.load_origin
  ) else $error("register write left a frame in progress");

  a_early_emit_dropped: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] && !front_stat.loaded
      |-> !f_valid
  ) else $error("emit before a loaded frame reached the queue");

endmodule

// ----- rtl/core/brp_front.sv -----
module brp_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned XW         = 10,
  parameter int unsigned YW         = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  brp_pkg::apb_req_t           apb_i,
  output logic [brp_pkg::APB_DW-1:0]  prdata_o,
  input  logic                        in_valid_i,
  input  brp_pkg::op_e                in_op_i,
  input  logic                        in_pixel_i,
  output logic                        in_ready_o,
  output logic                        cmd_valid_o,
  output brp_pkg::cmd_flags_t         cmd_flags_o,
  output logic [XW-1:0]               cmd_x_o,
  output logic [YW-1:0]               cmd_y_o,
  input  logic                        cmd_ready_i,
  output brp_pkg::front_stat_t        stat_o
);

  localparam logic [brp_pkg::DIM_W-1:0] WidthRst =
      brp_pkg::DIM_W'(MAX_WIDTH < 1024 ? MAX_WIDTH : 1024);
  localparam logic [brp_pkg::DIM_W-1:0] HeightRst =
      brp_pkg::DIM_W'(MAX_HEIGHT < 1024 ? MAX_HEIGHT : 1024);

  function automatic logic [brp_pkg::DIM_W-1:0] clamp_dim(
      input logic [brp_pkg::DIM_W-1:0] v, input int unsigned maxv);
    logic [brp_pkg::DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = brp_pkg::DIM_W'(1);
    end else if (32'(v) > maxv) begin
      r = brp_pkg::DIM_W'(maxv);
    end
    return r;
  endfunction

  logic [brp_pkg::DIM_W-1:0] width_q, width_d, height_q, height_d;
  logic [XW-1:0]             lx_q, lx_d, ex_q, ex_d;
  logic [YW-1:0]             ly_q, ly_d, ey_q, ey_d;
  logic                      loaded_q, loaded_d;

  logic cfg_wr, in_acc, is_load;
  logic lx_end, ly_end, ex_end, ey_end, load_origin;
  logic x_end, y_end;

  assign cfg_wr      = apb_i.sel && apb_i.enable && apb_i.write;
  assign in_ready_o  = cmd_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign is_load     = (in_op_i == brp_pkg::OP_LOAD);

  assign lx_end      = (32'(lx_q) + 32'd1) == 32'(width_q);
  assign ly_end      = (32'(ly_q) + 32'd1) == 32'(height_q);
  assign ex_end      = (32'(ex_q) + 32'd1) == 32'(width_q);
  assign ey_end      = (32'(ey_q) + 32'd1) == 32'(height_q);
  assign load_origin = (lx_q == '0) && (ly_q == '0);

  assign prdata_o = (apb_i.idx == brp_pkg::REG_FRAME_HEIGHT) ?
                    brp_pkg::APB_DW'(height_q) : brp_pkg::APB_DW'(width_q);

  // frame size registers and frame counters
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    lx_d     = lx_q;
    ly_d     = ly_q;
    ex_d     = ex_q;
    ey_d     = ey_q;
    loaded_d = loaded_q;
    if (cfg_wr) begin
      if (apb_i.idx == brp_pkg::REG_FRAME_HEIGHT) begin
        height_d = clamp_dim(apb_i.wdata, MAX_HEIGHT);
      end else begin
        width_d = clamp_dim(apb_i.wdata, MAX_WIDTH);
      end
      lx_d     = '0;
      ly_d     = '0;
      ex_d     = '0;
      ey_d     = '0;
      loaded_d = 1'b0;
    end else if (in_acc) begin
      if (is_load) begin
        if (load_origin) begin
          ex_d     = '0;
          ey_d     = '0;
          loaded_d = 1'b0;
        end
        if (lx_end && ly_end) begin
          lx_d     = '0;
          ly_d     = '0;
          loaded_d = 1'b1;
        end else if (lx_end) begin
          lx_d = '0;
          ly_d = ly_q + 1'b1;
        end else begin
          lx_d = lx_q + 1'b1;
        end
      end else if (loaded_q) begin
        if (ex_end && ey_end) begin
          ex_d = '0;
          ey_d = '0;
        end else if (ex_end) begin
          ex_d = '0;
          ey_d = ey_q + 1'b1;
        end else begin
          ex_d = ex_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      lx_q     <= '0;
      ly_q     <= '0;
      ex_q     <= '0;
      ey_q     <= '0;
      loaded_q <= 1'b0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      lx_q     <= lx_d;
      ly_q     <= ly_d;
      ex_q     <= ex_d;
      ey_q     <= ey_d;
      loaded_q <= loaded_d;
    end
  end

  // command toward the back end
  always_comb begin
    cmd_x_o = is_load ? lx_q : ex_q;
    cmd_y_o = is_load ? ly_q : ey_q;
    x_end   = is_load ? lx_end : ex_end;
    y_end   = is_load ? ly_end : ey_end;
    cmd_flags_o.op        = in_op_i;
    cmd_flags_o.pixel     = in_pixel_i;
    cmd_flags_o.row_end   = x_end;
    cmd_flags_o.frame_end = x_end && y_end;
    cmd_flags_o.x_start   = (cmd_x_o == '0);
    cmd_flags_o.y_start   = (cmd_y_o == '0);
  end

  // emits before a complete frame are dropped here
  assign cmd_valid_o = in_acc && (is_load || loaded_q);

  assign stat_o.loaded      = loaded_q;
  assign stat_o.load_origin = load_origin;

endmodule

// ----- rtl/core/brp_fifo.sv -----
module brp_fifo #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  logic [DW-1:0] push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output logic [DW-1:0] pop_data_o
);

  logic [DW-1:0]                 mem_q [brp_pkg::QUEUE_DEPTH];
  logic [brp_pkg::QUEUE_PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [brp_pkg::QUEUE_PW:0]    count_q, count_d;
  logic                          push, pop;

  assign push_ready_o = (32'(count_q) < brp_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/core/brp_back.sv -----
module brp_back #(
  parameter int unsigned XW = 10,
  parameter int unsigned YW = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  brp_pkg::cmd_flags_t cmd_flags_i,
  input  logic [XW-1:0]       cmd_x_i,
  input  logic [YW-1:0]       cmd_y_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_pixel_o,
  output logic                out_row_end_o,
  output logic                out_frame_end_o
);

  typedef struct packed {
    logic          has;
    logic [XW-1:0] first;
    logic [XW-1:0] last;
  } row_ent_t;

  typedef struct packed {
    logic          has;
    logic [YW-1:0] first;
    logic [YW-1:0] last;
  } col_ent_t;

  localparam int unsigned FsDepth = 2 ** (XW + YW);

  logic     fs_mem  [FsDepth];
  row_ent_t row_mem [2 ** YW];
  col_ent_t col_mem [2 ** XW];

  logic                b_valid_q, b_valid_d;
  brp_pkg::cmd_flags_t b_flags_q;
  logic [XW-1:0]       b_x_q;
  logic [YW-1:0]       b_y_q;

  logic     fs_rd_q;
  row_ent_t row_rd_q, run_q, row_base, row_new;
  col_ent_t col_rd_q, col_base, col_new;

  logic out_valid_q, out_pixel_q, out_row_end_q, out_frame_end_q;

  logic b_is_load, out_free, b_adv, pop;
  logic fs_we, row_we, col_we, cleared;
  logic [XW+YW-1:0] fs_ra, fs_wa;

  assign b_is_load   = (b_flags_q.op == brp_pkg::OP_LOAD);
  assign out_free    = !out_valid_q || out_ready_i;
  assign b_adv       = b_valid_q && (b_is_load || out_free);
  assign cmd_ready_o = !b_valid_q || b_adv;
  assign pop         = cmd_valid_i && cmd_ready_o;

  assign fs_we  = b_adv && b_is_load;
  assign col_we = fs_we;
  assign row_we = fs_we && b_flags_q.row_end;
  assign fs_ra  = {cmd_y_i, cmd_x_i};
  assign fs_wa  = {b_y_q, b_x_q};

  // running white span of the row being loaded
  always_comb begin
    row_base = b_flags_q.x_start ? '0 : run_q;
    row_new  = row_base;
    if (!b_flags_q.pixel) begin
      if (!row_base.has) begin
        row_new.first = b_x_q;
      end
      row_new.has  = 1'b1;
      row_new.last = b_x_q;
    end
  end

  // column span read, merged and written back
  always_comb begin
    col_base = b_flags_q.y_start ? '0 : col_rd_q;
    col_new  = col_base;
    if (!b_flags_q.pixel) begin
      if (!col_base.has) begin
        col_new.first = b_y_q;
      end
      col_new.has  = 1'b1;
      col_new.last = b_y_q;
    end
  end

  always_comb begin
    cleared = !row_rd_q.has || !col_rd_q.has
           || (b_x_q < row_rd_q.first) || (b_x_q > row_rd_q.last)
           || (b_y_q < col_rd_q.first) || (b_y_q > col_rd_q.last);
  end

  assign b_valid_d = pop ? 1'b1 : (b_adv ? 1'b0 : b_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
      if (b_adv && !b_is_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      b_flags_q <= cmd_flags_i;
      b_x_q     <= cmd_x_i;
      b_y_q     <= cmd_y_i;
    end
    if (fs_we) begin
      run_q <= row_new;
    end
    if (b_adv && !b_is_load) begin
      out_pixel_q     <= fs_rd_q && !cleared;
      out_row_end_q   <= b_flags_q.row_end;
      out_frame_end_q <= b_flags_q.frame_end;
    end
  end

  // frame store, write-first on a same-address read
  always_ff @(posedge clk_i) begin
    if (fs_we) begin
      fs_mem[fs_wa] <= b_flags_q.pixel;
    end
    if (pop) begin
      fs_rd_q <= (fs_we && (fs_wa == fs_ra)) ? b_flags_q.pixel : fs_mem[fs_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[b_y_q] <= row_new;
    end
    if (pop) begin
      row_rd_q <= (row_we && (b_y_q == cmd_y_i)) ? row_new : row_mem[cmd_y_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (col_we) begin
      col_mem[b_x_q] <= col_new;
    end
    if (pop) begin
      col_rd_q <= (col_we && (b_x_q == cmd_x_i)) ? col_new : col_mem[cmd_x_i];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_pixel_o     = out_pixel_q;
  assign out_row_end_o   = out_row_end_q;
  assign out_frame_end_o = out_frame_end_q;

endmodule
